// File: rtl/laai_pkg.sv
// Package: shared constants and types for the area address interner.
`timescale 1ns / 1ps
package laai_pkg;
   localparam int STORE_ENTRIES = 16;
   localparam int MAX_ADDR_BYTES = 13;
   localparam int MAX_LIST_ADDRS = 3;
   localparam int OPTION_BUFFER_BYTES = 256;
   localparam int IDX_W = $clog2(STORE_ENTRIES);
   localparam int EB_DEPTH = STORE_ENTRIES * MAX_ADDR_BYTES;
   localparam int EB_W = $clog2(EB_DEPTH);
   localparam int ALEN_W = $clog2(MAX_ADDR_BYTES + 1);

   localparam logic [2:0] ST_OK = 3'd0;
   localparam logic [2:0] ST_NO_AREA = 3'd1;
   localparam logic [2:0] ST_SHORT = 3'd2;
   localparam logic [2:0] ST_BAD_ADDR = 3'd3;
   localparam logic [2:0] ST_FULL = 3'd4;
   localparam logic [2:0] ST_OVERFLOW = 3'd5;

   localparam logic [0:0] REG_HEADER_BYTES = 1'd0;
   localparam logic [0:0] REG_AREA_CODE = 1'd1;

   typedef enum logic [2:0] {
      PH_HEADER = 3'd0,
      PH_CODE = 3'd1,
      PH_LEN = 3'd2,
      PH_VALUE = 3'd3,
      PH_SKIP = 3'd4,
      PH_DONE = 3'd5
   } phase_type;

   typedef enum logic [8:0] {
      S_IDLE = 9'b000000001,
      S_LHDR = 9'b000000010,
      S_CHK = 9'b000000100,
      S_SLOT = 9'b000001000,
      S_CMP = 9'b000010000,
      S_CPY = 9'b000100000,
      S_NEXT = 9'b001000000,
      S_OUT = 9'b010000000,
      S_ABBR = 9'b100000000
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic byte_step;   // accept input item
      logic load_alen;   // read address length byte from buffer
      logic chk;         // evaluate address checks
      logic slot_init;   // start at slot 0
      logic cmp_step;    // compare one byte
      logic cpy_step;    // copy one byte
      logic slot_next;   // advance slot
      logic commit_idx;  // record slot index
      logic fail_full;
      logic list_done;
      logic emit;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic list_start;  // area option complete, walk list
      logic is_last;
      logic list_end;    // pos reached length
      logic chk_fail;
      logic slot_empty;
      logic slot_len_eq;
      logic byte_done;   // k reached alen
      logic byte_diff;
      logic slot_last;
   } sts_type;
endpackage

// File: rtl/laai_if.sv
// Interfaces: valid/ready channels for items, results and configuration.
`timescale 1ns / 1ps
interface laai_req_if (input logic clock);
   logic valid;
   logic ready;
   logic [7:0] data_byte;
   logic last_byte;
   modport source (output valid, data_byte, last_byte, input ready);
   modport sink (input valid, data_byte, last_byte, output ready);
endinterface

interface laai_rsp_if (input logic clock);
   logic valid;
   logic ready;
   logic [2:0] status;
   logic [1:0] address_count;
   logic [3:0] first_index;
   logic [3:0] second_index;
   logic [3:0] third_index;
   modport source (output valid, status, address_count, first_index, second_index,
      third_index, input ready);
   modport sink (input valid, status, address_count, first_index, second_index,
      third_index, output ready);
endinterface

interface laai_csr_if (input logic clock);
   logic valid;
   logic ready;
   logic [0:0] index;
   logic [7:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// File: rtl/laai_ctrl.sv
// Controller: sequences byte intake, list walk and store search.
`timescale 1ns / 1ps
module laai_ctrl (
   input logic clock,
   input logic reset,
   input logic req_fire,
   input logic rsp_fire,
   input laai_pkg::sts_type sts,
   output laai_pkg::cmd_type cmd,
   output logic busy,
   output logic rsp_pend
);
   laai_pkg::state_type state_ff, state_in;
   logic last_ff, last_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= laai_pkg::S_IDLE;
         last_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         last_ff <= last_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      last_in = last_ff;
      cmd = '0;
      unique case (state_ff)
         laai_pkg::S_IDLE: begin
            if (req_fire) begin
               cmd.byte_step = 1'b1;
               last_in = sts.is_last;
               state_in = laai_pkg::S_LHDR;
            end
         end
         laai_pkg::S_LHDR: begin
            if (sts.list_start) begin
               state_in = laai_pkg::S_CHK;
               cmd.load_alen = 1'b1;
               cmd.slot_init = 1'b1;
            end else if (last_ff) state_in = laai_pkg::S_OUT;
            else state_in = laai_pkg::S_IDLE;
         end
         laai_pkg::S_CHK: begin
            if (sts.list_end) begin
               cmd.list_done = 1'b1;
               state_in = last_ff ? laai_pkg::S_OUT : laai_pkg::S_IDLE;
            end else begin
               cmd.chk = 1'b1;
               if (sts.chk_fail) state_in = last_ff ? laai_pkg::S_OUT : laai_pkg::S_IDLE;
               else begin
                  cmd.slot_init = 1'b1;
                  state_in = laai_pkg::S_SLOT;
               end
            end
         end
         laai_pkg::S_SLOT: begin
            if (sts.slot_empty) state_in = laai_pkg::S_CPY;
            else if (sts.slot_len_eq) state_in = laai_pkg::S_CMP;
            else state_in = laai_pkg::S_ABBR;
         end
         laai_pkg::S_CMP: begin
            if (sts.byte_done) begin
               cmd.commit_idx = 1'b1;
               state_in = laai_pkg::S_NEXT;
            end else if (sts.byte_diff) state_in = laai_pkg::S_ABBR;
            else cmd.cmp_step = 1'b1;
         end
         laai_pkg::S_CPY: begin
            if (sts.byte_done) begin
               cmd.commit_idx = 1'b1;
               state_in = laai_pkg::S_NEXT;
            end else cmd.cpy_step = 1'b1;
         end
         laai_pkg::S_ABBR: begin
            if (sts.slot_last) begin
               cmd.fail_full = 1'b1;
               state_in = last_ff ? laai_pkg::S_OUT : laai_pkg::S_IDLE;
            end else begin
               cmd.slot_next = 1'b1;
               state_in = laai_pkg::S_SLOT;
            end
         end
         laai_pkg::S_NEXT: begin
            cmd.load_alen = 1'b1;
            state_in = laai_pkg::S_CHK;
         end
         laai_pkg::S_OUT: begin
            cmd.emit = 1'b1;
            last_in = 1'b0;
            state_in = laai_pkg::S_IDLE;
         end
         default: state_in = laai_pkg::S_IDLE;
      endcase
   end

   assign busy = (state_ff != laai_pkg::S_IDLE);
   // result register occupancy
   logic pend_ff;
   always_ff @(posedge clock) begin
      if (reset) pend_ff <= 1'b0;
      else if (cmd.emit) pend_ff <= 1'b1;
      else if (rsp_fire) pend_ff <= 1'b0;
   end
   assign rsp_pend = pend_ff;
endmodule

// File: rtl/laai_dp.sv
// Datapath: parser registers, option buffer, address store and result register.
`timescale 1ns / 1ps
module laai_dp (
   input logic clock,
   input logic reset,
   input laai_pkg::cmd_type cmd,
   output laai_pkg::sts_type sts,
   input logic [7:0] in_byte,
   input logic in_last,
   input logic csr_we,
   input logic [0:0] csr_idx,
   input logic [7:0] csr_data,
   output logic [2:0] r_status,
   output logic [1:0] r_count,
   output logic [3:0] r_idx0,
   output logic [3:0] r_idx1,
   output logic [3:0] r_idx2
);
   localparam int IW = laai_pkg::IDX_W;
   localparam int AW = laai_pkg::ALEN_W;
   localparam int EW = laai_pkg::EB_W;

   logic [7:0] hdr_cfg_ff, code_cfg_ff;
   logic [7:0] obuf [laai_pkg::OPTION_BUFFER_BYTES];
   logic [7:0] ebytes [laai_pkg::EB_DEPTH];
   logic [AW-1:0] elen_ff [laai_pkg::STORE_ENTRIES];

   logic started_ff;
   logic [7:0] hcnt_ff, code_ff, rem_ff, fill_ff;
   laai_pkg::phase_type ph_ff;
   logic [2:0] pst_ff;
   logic [1:0] cnt_ff;
   logic [3:0] idx_ff [3];
   logic start_ff;
   logic [8:0] pos_ff, len_ff;
   logic [7:0] alen_ff;
   logic [IW-1:0] slot_ff;
   logic [AW-1:0] k_ff;
   logic [EW-1:0] ebase_ff;
   logic [7:0] ob_q, eb_q;

   // buffer read address: len byte during check, address byte during walk
   logic [7:0] rd_a;
   logic [EW-1:0] ea;
   logic [8:0] nxt_pos;
   assign nxt_pos = pos_ff + 9'(alen_ff) + 9'd1;
   always_comb begin
      if (cmd.load_alen) rd_a = cmd.slot_init ? pos_ff[7:0] : nxt_pos[7:0];
      else if (cmd.cmp_step || cmd.cpy_step) rd_a = 8'(pos_ff + 9'd2 + 9'(k_ff));
      else rd_a = 8'(pos_ff + 9'd1);
   end
   assign ea = ebase_ff + EW'(k_ff);

   always_ff @(posedge clock) begin
      if (cmd.byte_step && ph_ff == laai_pkg::PH_VALUE) obuf[fill_ff] <= in_byte;
      ob_q <= obuf[rd_a];
      if (cmd.cpy_step) ebytes[ea] <= ob_q;
      eb_q <= ebytes[(cmd.cmp_step || cmd.cpy_step) ? EW'(ea + EW'(1)) : ea];
   end

   logic [8:0] left;
   assign left = len_ff - pos_ff - 9'd1;

   always_comb begin
      sts.is_last = in_last;
      sts.list_start = start_ff;
      sts.list_end = (pos_ff >= len_ff);
      sts.chk_fail = (ob_q == 8'd0) || (9'(ob_q) > left) ||
         (ob_q > 8'(laai_pkg::MAX_ADDR_BYTES)) || (cnt_ff >= 2'(laai_pkg::MAX_LIST_ADDRS));
      sts.slot_empty = (elen_ff[slot_ff] == '0);
      sts.slot_len_eq = (8'(elen_ff[slot_ff]) == alen_ff);
      sts.byte_done = (8'(k_ff) == alen_ff);
      sts.byte_diff = (ob_q != eb_q);
      sts.slot_last = (slot_ff == IW'(laai_pkg::STORE_ENTRIES - 1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hdr_cfg_ff <= 8'd27;
         code_cfg_ff <= 8'd1;
         for (int i = 0; i < laai_pkg::STORE_ENTRIES; i++) elen_ff[i] <= '0;
         started_ff <= 1'b0;
         ph_ff <= laai_pkg::PH_HEADER;
         hcnt_ff <= '0; code_ff <= '0; rem_ff <= '0; fill_ff <= '0;
         pst_ff <= laai_pkg::ST_NO_AREA;
         cnt_ff <= '0;
         start_ff <= 1'b0;
         pos_ff <= '0; len_ff <= '0; alen_ff <= '0; slot_ff <= '0; k_ff <= '0;
         ebase_ff <= '0;
         for (int i = 0; i < 3; i++) idx_ff[i] <= '0;
      end else begin
         start_ff <= 1'b0;
         if (csr_we) begin
            unique case (csr_idx)
               laai_pkg::REG_HEADER_BYTES: hdr_cfg_ff <= csr_data;
               laai_pkg::REG_AREA_CODE: code_cfg_ff <= csr_data;
               default: ;
            endcase
         end
         if (cmd.byte_step) begin : step
            logic [7:0] hc;
            logic cons;
            hc = started_ff ? hcnt_ff : hdr_cfg_ff;
            cons = (ph_ff == laai_pkg::PH_HEADER) && (hc != 8'd0);
            started_ff <= 1'b1;
            if (ph_ff == laai_pkg::PH_HEADER) hcnt_ff <= cons ? hc - 8'd1 : hc;
            if (!cons) begin
               case (ph_ff)
                  laai_pkg::PH_HEADER, laai_pkg::PH_CODE: begin
                     code_ff <= in_byte;
                     ph_ff <= laai_pkg::PH_LEN;
                  end
                  laai_pkg::PH_LEN: begin
                     rem_ff <= in_byte;
                     fill_ff <= '0;
                     if (code_ff == code_cfg_ff) begin
                        ph_ff <= (in_byte == 8'd0) ? laai_pkg::PH_DONE : laai_pkg::PH_VALUE;
                        if (in_byte == 8'd0) begin
                           pst_ff <= laai_pkg::ST_OK;
                           cnt_ff <= '0;
                        end
                     end else ph_ff <= (in_byte == 8'd0) ? laai_pkg::PH_CODE : laai_pkg::PH_SKIP;
                  end
                  laai_pkg::PH_VALUE: begin
                     fill_ff <= fill_ff + 8'd1;
                     rem_ff <= rem_ff - 8'd1;
                     if (rem_ff == 8'd1) begin
                        ph_ff <= laai_pkg::PH_DONE;
                        start_ff <= 1'b1;
                        pos_ff <= '0;
                        cnt_ff <= '0;
                        len_ff <= 9'(fill_ff) + 9'd1;
                     end
                  end
                  laai_pkg::PH_SKIP: begin
                     rem_ff <= rem_ff - 8'd1;
                     if (rem_ff == 8'd1) ph_ff <= laai_pkg::PH_CODE;
                  end
                  default: ;
               endcase
            end
            if (in_last) begin
               if (!cons && ((ph_ff == laai_pkg::PH_LEN && code_ff == code_cfg_ff &&
                     in_byte != 8'd0) || (ph_ff == laai_pkg::PH_LEN && code_ff != code_cfg_ff
                     && in_byte != 8'd0) || (ph_ff == laai_pkg::PH_VALUE && rem_ff != 8'd1)
                     || (ph_ff == laai_pkg::PH_SKIP && rem_ff != 8'd1))) begin
                  pst_ff <= laai_pkg::ST_SHORT;
                  cnt_ff <= '0;
               end
            end
         end
         if (cmd.load_alen) begin
            if (!cmd.slot_init) pos_ff <= nxt_pos;
         end
         if (cmd.chk) begin
            alen_ff <= ob_q;
            if (sts.chk_fail) begin
               pst_ff <= ((ob_q == 8'd0) || (9'(ob_q) > left) ||
                  (ob_q > 8'(laai_pkg::MAX_ADDR_BYTES))) ? laai_pkg::ST_BAD_ADDR :
                  laai_pkg::ST_OVERFLOW;
               cnt_ff <= '0;
            end
         end
         if (cmd.slot_init) begin
            slot_ff <= '0;
            ebase_ff <= '0;
            k_ff <= '0;
         end
         if (cmd.cmp_step || cmd.cpy_step) k_ff <= k_ff + AW'(1);
         if (cmd.slot_next) begin
            slot_ff <= slot_ff + IW'(1);
            ebase_ff <= ebase_ff + EW'(laai_pkg::MAX_ADDR_BYTES);
            k_ff <= '0;
         end
         if (cmd.commit_idx) begin
            if (sts.slot_empty) elen_ff[slot_ff] <= AW'(alen_ff);
            idx_ff[cnt_ff] <= 4'(slot_ff);
            cnt_ff <= cnt_ff + 2'd1;
         end
         if (cmd.fail_full) begin
            pst_ff <= laai_pkg::ST_FULL;
            cnt_ff <= '0;
         end
         if (cmd.list_done) pst_ff <= laai_pkg::ST_OK;
         if (cmd.emit) begin
            started_ff <= 1'b0;
            ph_ff <= laai_pkg::PH_HEADER;
            pst_ff <= laai_pkg::ST_NO_AREA;
            cnt_ff <= '0;
            for (int i = 0; i < 3; i++) idx_ff[i] <= '0;
         end
      end
   end

   // result register
   logic [1:0] oc;
   assign oc = (pst_ff == laai_pkg::ST_OK) ? cnt_ff : 2'd0;
   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         r_status <= pst_ff;
         r_count <= oc;
         r_idx0 <= (oc > 2'd0) ? idx_ff[0] : 4'd0;
         r_idx1 <= (oc > 2'd1) ? idx_ff[1] : 4'd0;
         r_idx2 <= (oc > 2'd2) ? idx_ff[2] : 4'd0;
      end
   end
endmodule

// File: rtl/lsp_area_address_interner_top.sv
// Top level: area address option parser and address interner.
`timescale 1ns / 1ps
// Takes one packet byte per item and takes no new item while it is busy with
// the last one. After the last byte of the area option the block stops taking
// items while it walks the address list and searches the 16-entry store one
// byte per cycle. One result is given per packet; a result waiting to be taken
// blocks the next packet's final byte.
module lsp_area_address_interner_top (
   input logic clock,
   input logic reset,
   laai_req_if.sink req,
   laai_rsp_if.source rsp,
   laai_csr_if.sink csr
);
   laai_pkg::cmd_type cmd;
   laai_pkg::sts_type sts;
   logic busy, rsp_pend;
   logic req_fire, rsp_fire;

   assign req.ready = !busy && !(rsp_pend && req.last_byte);
   assign req_fire = req.valid && req.ready;
   assign rsp_fire = rsp.valid && rsp.ready;
   assign rsp.valid = rsp_pend;
   assign csr.ready = 1'b1;

   laai_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_fire(req_fire), .rsp_fire(rsp_fire),
      .sts(sts), .cmd(cmd), .busy(busy), .rsp_pend(rsp_pend)
   );

   laai_dp u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .sts(sts),
      .in_byte(req.data_byte), .in_last(req.last_byte),
      .csr_we(csr.valid && csr.ready), .csr_idx(csr.index), .csr_data(csr.data),
      .r_status(rsp.status), .r_count(rsp.address_count), .r_idx0(rsp.first_index),
      .r_idx1(rsp.second_index), .r_idx2(rsp.third_index)
   );

`ifndef SYNTH
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> !rsp_pend) else $error("result overwritten");
   a_no_take_busy: assert property (@(posedge clock) disable iff (reset)
      busy |-> !req.ready) else $error("item taken while busy");
   a_emit_pend: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> rsp_pend) else $error("result lost");
`endif
endmodule
